@@ rtl/round_rest_interval_timer_macros.svh @@
// Assertion macros shared by the round and rest interval timer RTL.
`ifndef ROUND_REST_INTERVAL_TIMER_MACROS_SVH
`define ROUND_REST_INTERVAL_TIMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRIT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("round_rest_interval_timer: assertion failed");

// Consequent must hold starting in the cycle after the antecedent.
`define RRIT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("round_rest_interval_timer: assertion failed");

`endif

@@ rtl/rrit_pkg.sv @@
// Types, constants and the microcode program of the round and rest interval timer.
package rrit_pkg;

	localparam int unsigned STEP_W = 4;

	typedef logic [STEP_W-1:0] step_t;

	// Commands carried by an input transaction.
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_TOGGLE = 2'd1;
	localparam logic [1:0] CMD_RESET  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ROUND   = 2'd0;
	localparam logic [1:0] REG_REST    = 2'd1;
	localparam logic [1:0] REG_WARNING = 2'd2;
	localparam logic [1:0] REG_TOTAL   = 2'd3;

	// Period codes; PER_NONE marks that no period has been seen yet.
	localparam logic [1:0] PER_ROUND = 2'd0;
	localparam logic [1:0] PER_WARN  = 2'd1;
	localparam logic [1:0] PER_REST  = 2'd2;
	localparam logic [1:0] PER_NONE  = 2'd3;

	// Alert codes.
	localparam logic [1:0] ALERT_NONE   = 2'd0;
	localparam logic [1:0] ALERT_WARN   = 2'd1;
	localparam logic [1:0] ALERT_CHANGE = 2'd2;
	localparam logic [1:0] ALERT_DONE   = 2'd3;

	localparam logic [31:0] TICK_MS = 32'd100;

	localparam logic [21:0] ROUND_RESET   = 22'd180000;
	localparam logic [21:0] REST_RESET    = 22'd60000;
	localparam logic [21:0] WARNING_RESET = 22'd10000;
	localparam logic [6:0]  TOTAL_RESET   = 7'd12;

	// Datapath operations selected by the control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_TICK_ADD,
		OP_TICK_SYNC,
		OP_CMD,
		OP_DIV_INIT,
		OP_EVAL,
		OP_OUT
	} op_t;

	// Jump conditions; a true condition loads the target, otherwise the step advances.
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_NO_ACCEPT,
		JC_NOT_TICK_RUN,
		JC_DIV_BUSY,
		JC_OUT_FULL
	} jc_t;

	typedef struct packed {
		op_t   op;
		jc_t   jc;
		step_t target;
	} uword_t;

	// Status flags sampled by the sequencer for its jumps.
	typedef struct packed {
		logic accept;
		logic tick_run;
		logic div_busy;
		logic out_full;
	} stat_t;

	// Microcode program, one control word per step.
	function automatic uword_t ucode_rom(input step_t step);
		uword_t w;
		unique case (step)
			4'd0:    w = '{op: OP_LATCH,     jc: JC_NO_ACCEPT,    target: 4'd0};
			4'd1:    w = '{op: OP_NOP,       jc: JC_NOT_TICK_RUN, target: 4'd4};
			4'd2:    w = '{op: OP_TICK_ADD,  jc: JC_NEXT,         target: 4'd0};
			4'd3:    w = '{op: OP_TICK_SYNC, jc: JC_ALWAYS,       target: 4'd5};
			4'd4:    w = '{op: OP_CMD,       jc: JC_NEXT,         target: 4'd0};
			4'd5:    w = '{op: OP_DIV_INIT,  jc: JC_NEXT,         target: 4'd0};
			4'd6:    w = '{op: OP_NOP,       jc: JC_DIV_BUSY,     target: 4'd6};
			4'd7:    w = '{op: OP_EVAL,      jc: JC_NEXT,         target: 4'd0};
			4'd8:    w = '{op: OP_OUT,       jc: JC_OUT_FULL,     target: 4'd8};
			default: w = '{op: OP_NOP,       jc: JC_ALWAYS,       target: 4'd0};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/rrit_if.sv @@
// Channel interfaces of the round and rest interval timer.
interface rrit_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] wall_time_ms;

	modport source (output valid, command, wall_time_ms, input ready);
	modport sink (input valid, command, wall_time_ms, output ready);
endinterface

interface rrit_result_if;
	logic        valid;
	logic        ready;
	logic [21:0] countdown_ms;
	logic [1:0]  period;
	logic [6:0]  rounds_left;
	logic        running;
	logic [1:0]  alert;

	modport source (output valid, countdown_ms, period, rounds_left, running, alert,
		input ready);
	modport sink (input valid, countdown_ms, period, rounds_left, running, alert,
		output ready);
endinterface

interface rrit_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [21:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/rrit_div.sv @@
// Restoring divider, one quotient bit per cycle, for the cycle position.
module rrit_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [22:0] divisor,
	output logic        busy,
	output logic [31:0] quotient,
	output logic [22:0] remainder
);

	logic        busy_q;
	logic [4:0]  count_q;
	logic [31:0] quo_q;
	logic [22:0] rem_q;
	logic [22:0] div_q;
	logic [23:0] trial;
	logic        ge;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			count_q <= '0;
		end else if (busy_q) begin
			count_q <= count_q + 5'd1;
			if (count_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], ge};
			rem_q <= ge ? 23'(trial - {1'b0, div_q}) : trial[22:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ rtl/rrit_seq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
module rrit_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  rrit_pkg::stat_t stat,
	output rrit_pkg::op_t   op
);

	rrit_pkg::step_t  step_q;
	rrit_pkg::step_t  step_d;
	rrit_pkg::uword_t uw;
	logic             take;

	assign uw = rrit_pkg::ucode_rom(step_q);

	always_comb begin
		unique case (uw.jc)
			rrit_pkg::JC_NEXT:         take = 1'b0;
			rrit_pkg::JC_ALWAYS:       take = 1'b1;
			rrit_pkg::JC_NO_ACCEPT:    take = !stat.accept;
			rrit_pkg::JC_NOT_TICK_RUN: take = !stat.tick_run;
			rrit_pkg::JC_DIV_BUSY:     take = stat.div_busy;
			rrit_pkg::JC_OUT_FULL:     take = stat.out_full;
			default:                   take = 1'b1;
		endcase
	end

	assign step_d = take ? uw.target : rrit_pkg::step_t'(step_q + 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_d;
		end
	end

	assign op = uw.op;

endmodule

@@ rtl/round_rest_interval_timer.sv @@
// Top level of the round and rest interval timer: datapath, sequencer and divider.
//
// The timer takes one command transaction at a time and returns exactly one result
// transaction for it. The microcode spends one step on the decode. A running tick
// then takes two steps and any other command one. One step starts the bit-serial
// divider, which splits elapsed time into completed rounds and the position inside
// the current round plus rest cycle. A wait step holds until the divider has built
// all quotient bits and is seen idle; this wait is the longest part of the work on
// a command. Two more steps judge the period and load the result register, and one
// step returns to the input step. Input ready is high only while the sequencer sits
// at its first step. A result waits in its own output register, so the next command
// is taken while the previous result is still unread, and the sequencer only
// stalls when a second result is due before the first has gone. Configuration
// writes are always taken and should only be issued while the timer has no command
// in progress.
`include "round_rest_interval_timer_macros.svh"

module round_rest_interval_timer (
	input  logic          clk,
	input  logic          arst_n,
	rrit_cfg_if.sink      cfg,
	rrit_item_if.sink     item,
	rrit_result_if.source result
);

	// Configuration registers.
	logic [21:0] round_q;
	logic [21:0] rest_q;
	logic [21:0] warning_q;
	logic [6:0]  total_q;

	// Timer state.
	logic [31:0] elapsed_q;
	logic        running_q;
	logic [31:0] offset_q;
	logic [31:0] last_q;
	logic [1:0]  prev_q;
	logic        tick_q;
	logic [1:0]  alert_q;

	// The command transaction being worked on.
	logic [1:0]  cmd_q;
	logic [31:0] wall_q;

	// Result register.
	logic        out_valid_q;
	logic [21:0] countdown_q;
	logic [1:0]  period_q;
	logic [6:0]  left_q;
	logic        out_running_q;
	logic [1:0]  out_alert_q;

	rrit_pkg::op_t   op;
	rrit_pkg::stat_t stat;

	logic        in_accept;
	logic        out_full;
	logic        div_start;
	logic        div_busy;
	logic [31:0] div_quo;
	logic [22:0] div_rem;

	logic [21:0] rl_eff;
	logic [22:0] full_len;
	logic        at_zero;
	logic [22:0] pos;
	logic [31:0] cnt;
	logic        in_round;
	logic        warn_hit;
	logic [1:0]  per;
	logic [21:0] countdown;
	logic [6:0]  left;
	logic        done_hit;
	logic [31:0] tick_elapsed;

	// Configuration port: a write is taken in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q   <= rrit_pkg::ROUND_RESET;
			rest_q    <= rrit_pkg::REST_RESET;
			warning_q <= rrit_pkg::WARNING_RESET;
			total_q   <= rrit_pkg::TOTAL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rrit_pkg::REG_ROUND:   round_q   <= cfg.data;
				rrit_pkg::REG_REST:    rest_q    <= cfg.data;
				rrit_pkg::REG_WARNING: warning_q <= cfg.data;
				rrit_pkg::REG_TOTAL:   total_q   <= cfg.data[6:0];
				default:               ;
			endcase
		end
	end

	// Handshake and sequencer status.
	assign item.ready = (op == rrit_pkg::OP_LATCH);
	assign in_accept  = item.valid && item.ready;
	assign out_full   = out_valid_q && !result.ready;
	assign div_start  = (op == rrit_pkg::OP_DIV_INIT);

	assign stat.accept   = in_accept;
	assign stat.tick_run = (cmd_q == rrit_pkg::CMD_TICK) && running_q;
	assign stat.div_busy = div_busy;
	assign stat.out_full = out_full;

	rrit_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.op     (op)
	);

	// A round length of zero counts as one millisecond. The full cycle is the round
	// plus the rest and never exceeds 23 bits.
	assign rl_eff   = (round_q == '0) ? 22'd1 : round_q;
	assign full_len = {1'b0, rl_eff} + {1'b0, rest_q};

	// The divider works on elapsed minus one, so an exact multiple of the full cycle
	// stays at the end of its rest period instead of wrapping to zero.
	rrit_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (elapsed_q - 32'd1),
		.divisor   (full_len),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Position inside the cycle and completed rounds. Zero elapsed time is its own
	// case; that also covers a timer just cleared by the end of all rounds, whose
	// elapsed time no longer matches the last division.
	assign at_zero = (elapsed_q == '0);
	assign pos     = at_zero ? '0 : 23'(div_rem + 23'd1);
	assign cnt     = at_zero ? '0 : div_quo;

	// The warning applies whenever the round time left is shorter than the window,
	// which makes the whole round a warning when the window is the longer one.
	assign in_round = pos < {1'b0, rl_eff};
	assign warn_hit = (warning_q != '0) &&
		(({1'b0, pos} + {2'b0, warning_q}) > {2'b0, rl_eff});

	always_comb begin
		if (!in_round) begin
			per = rrit_pkg::PER_REST;
		end else if (warn_hit) begin
			per = rrit_pkg::PER_WARN;
		end else begin
			per = rrit_pkg::PER_ROUND;
		end
	end

	assign countdown = in_round ? 22'({1'b0, rl_eff} - pos)
		: 22'({1'b0, rest_q} - (pos - {1'b0, rl_eff}));

	assign left = ((total_q == '0) || (cnt >= {25'b0, total_q})) ? '0
		: 7'(total_q - cnt[6:0]);

	assign done_hit = (total_q != '0) && (cnt == {25'b0, total_q});

	assign tick_elapsed = elapsed_q + rrit_pkg::TICK_MS;

	// Datapath state, stepped by the operation of the current control word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			running_q <= 1'b0;
			offset_q  <= '0;
			last_q    <= '0;
			prev_q    <= rrit_pkg::PER_NONE;
			tick_q    <= 1'b0;
			alert_q   <= rrit_pkg::ALERT_NONE;
		end else begin
			case (op)
				rrit_pkg::OP_LATCH: begin
					if (in_accept) begin
						tick_q  <= 1'b0;
						alert_q <= rrit_pkg::ALERT_NONE;
					end
				end
				rrit_pkg::OP_TICK_ADD: begin
					// Advance by one tick and capture the first wall clock sample.
					tick_q    <= 1'b1;
					elapsed_q <= tick_elapsed;
					if (last_q == '0) begin
						last_q <= wall_q;
					end
				end
				rrit_pkg::OP_TICK_SYNC: begin
					// Once the wall clock moves on, either capture the offset or
					// follow the wall clock through it. A captured offset of zero
					// reads as not captured and is taken again next time.
					if (wall_q > last_q) begin
						if (offset_q == '0) begin
							offset_q <= wall_q - elapsed_q;
						end else begin
							elapsed_q <= wall_q - offset_q;
						end
						last_q <= wall_q;
					end
				end
				rrit_pkg::OP_CMD: begin
					case (cmd_q)
						rrit_pkg::CMD_TOGGLE: begin
							running_q <= !running_q;
							if (!running_q) begin
								offset_q <= '0;
								last_q   <= '0;
							end
						end
						rrit_pkg::CMD_RESET: begin
							// A running timer restarts; a stopped one stays stopped.
							elapsed_q <= '0;
							offset_q  <= '0;
							last_q    <= '0;
							prev_q    <= rrit_pkg::PER_NONE;
						end
						default: ;
					endcase
				end
				rrit_pkg::OP_EVAL: begin
					if (tick_q && (per != prev_q)) begin
						if (done_hit) begin
							elapsed_q <= '0;
							offset_q  <= '0;
							last_q    <= '0;
							prev_q    <= rrit_pkg::PER_NONE;
							running_q <= 1'b0;
							alert_q   <= rrit_pkg::ALERT_DONE;
						end else begin
							alert_q <= (per == rrit_pkg::PER_WARN) ? rrit_pkg::ALERT_WARN
								: rrit_pkg::ALERT_CHANGE;
							prev_q  <= per;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Command payload is captured on acceptance.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q  <= item.command;
			wall_q <= item.wall_time_ms;
		end
	end

	// Result register. It loads at the output step once the previous result is
	// gone or leaves in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((op == rrit_pkg::OP_OUT) && !out_full) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((op == rrit_pkg::OP_OUT) && !out_full) begin
			countdown_q   <= countdown;
			period_q      <= per;
			left_q        <= left;
			out_running_q <= running_q;
			out_alert_q   <= alert_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.countdown_ms = countdown_q;
	assign result.period       = period_q;
	assign result.rounds_left  = left_q;
	assign result.running      = out_running_q;
	assign result.alert        = out_alert_q;

	// The end of all rounds stops the timer and reports a fresh start.
	`RRIT_ASSERT_NOW(a_done_result, result.valid && (result.alert == rrit_pkg::ALERT_DONE), !result.running && (result.rounds_left == total_q))
	// A new command is never taken while a division is still in progress.
	`RRIT_ASSERT_NOW(a_accept_div_idle, in_accept, !div_busy)
	// A division keeps the divider busy from its start until all quotient bits are done, then it goes idle.
	`RRIT_ASSERT_NEXT(a_div_length, div_start, div_busy ##31 div_busy ##1 !div_busy)

endmodule
